// File: src/sta_pkg.sv
// Shared types and constants for the scaled time accumulator.
// No dependencies; compiled first.
package sta_pkg;

    // Fraction bits of the Q-format speed register
    localparam int FRAC_BITS = 16;

    // Speed register value for real-time speed
    localparam logic [31:0] TIME_SCALE_RESET = 32'd1 << FRAC_BITS;

    // Saturation limits of the signed step, as magnitudes
    localparam logic [63:0] STEP_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] STEP_NEG_MAX = 64'h0000_0000_8000_0000;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_PAUSE  = 2'd1,
        OP_RESUME = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

endpackage

// File: src/sta_if.sv
// Request and response channel interfaces of the scaled time accumulator.
// Depends on nothing but the package order; valid/ready handshake.
interface sta_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] current_time;

    modport source (output valid, output operation, output current_time, input ready);
    modport sink   (input valid, input operation, input current_time, output ready);
endinterface

interface sta_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] warped_time;
    logic        already_paused;
    logic        step_clamped;

    modport source (output valid, output warped_time, output already_paused,
                    output step_clamped, input ready);
    modport sink   (input valid, input warped_time, input already_paused,
                    input step_clamped, output ready);
endinterface

// File: src/scaled_time_accumulator.sv
// Scaled time accumulator: warped time driven by real time at a signed speed.
// Depends on sta_pkg and the channel interfaces in sta_if.sv.
//
// Usage:
//   req carries an operation (update, pause, resume, reset) and the current
//   real time; rsp returns one result per request: the warped time after the
//   operation plus the already_paused and step_clamped flags.
//   time_scale_we / time_scale_data write the signed Q16.16 speed; write it
//   only while no request is in flight.
// Pipeline and throughput:
//   An accepted request lands in the input register; the result is computed
//   from it and the state registers and loaded into the result register
//   once that register is free. One request per cycle sustained while
//   rsp.ready stays high. The cycle path is one 32x32 multiply, a saturate
//   and a 32-bit add/subtract with floor at zero.
// Reset:
//   rst_n clears the valid bits of both pipeline registers and the state; the
//   speed returns to real time.
// Stall:
//   While rsp.ready is low the result holds, and the input register still
//   takes one more request; req.ready drops only when both are full.
module scaled_time_accumulator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             time_scale_we,
    input  logic [31:0]      time_scale_data,
    sta_req_if.sink          req,
    sta_rsp_if.source        rsp
);

    // Configuration and state
    logic [31:0] time_scale_reg;
    logic [31:0] last_real_time_reg, last_real_time_next;
    logic [31:0] relative_time_reg,  relative_time_next;
    logic [31:0] pause_mark_reg,     pause_mark_next;

    // Input register
    logic           in_valid_reg;
    sta_pkg::op_t   in_op_reg;
    logic [31:0]    in_time_reg;

    // Result register
    logic           out_valid_reg;
    logic [31:0]    out_warped_reg;
    logic           out_paused_reg;
    logic           out_clamped_reg;

    logic           fire;
    logic           out_free;

    // Step arithmetic
    logic           scale_neg;
    logic [31:0]    scale_mag;
    logic [31:0]    elapsed;
    logic [63:0]    product;
    logic [63:0]    quotient;
    logic [31:0]    step_mag;
    logic           step_neg;
    logic           paused_flag;
    logic           clamped_flag;

    // Handshake: result register frees up when empty or taken
    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    assign rsp.valid          = out_valid_reg;
    assign rsp.warped_time    = out_warped_reg;
    assign rsp.already_paused = out_paused_reg;
    assign rsp.step_clamped   = out_clamped_reg;

    // Scaled step: magnitude of speed times elapsed, truncated and saturated
    always_comb
    begin
        scale_neg = time_scale_reg[31];
        scale_mag = scale_neg ? (~time_scale_reg + 32'd1) : time_scale_reg;
        elapsed   = in_time_reg - last_real_time_reg;
        product   = {32'd0, elapsed} * {32'd0, scale_mag};
        quotient  = product >> sta_pkg::FRAC_BITS;
        if (scale_neg && quotient > sta_pkg::STEP_NEG_MAX)
        begin
            step_mag = sta_pkg::STEP_NEG_MAX[31:0];
        end
        else if (!scale_neg && quotient > sta_pkg::STEP_POS_MAX)
        begin
            step_mag = sta_pkg::STEP_POS_MAX[31:0];
        end
        else
        begin
            step_mag = quotient[31:0];
        end
        step_neg = scale_neg && (step_mag != 32'd0);
    end

    // Operation decode and next state
    always_comb
    begin
        last_real_time_next = last_real_time_reg;
        relative_time_next  = relative_time_reg;
        pause_mark_next     = pause_mark_reg;
        paused_flag         = 1'b0;
        clamped_flag        = 1'b0;
        unique case (in_op_reg)
            sta_pkg::OP_UPDATE:
            begin
                last_real_time_next = in_time_reg;
                if (!step_neg)
                begin
                    relative_time_next = relative_time_reg + step_mag;
                end
                else if (step_mag > relative_time_reg)
                begin
                    relative_time_next = 32'd0;
                    clamped_flag       = 1'b1;
                end
                else
                begin
                    relative_time_next = relative_time_reg - step_mag;
                end
            end
            sta_pkg::OP_PAUSE:
            begin
                if (pause_mark_reg != 32'd0)
                begin
                    paused_flag = 1'b1;
                end
                else
                begin
                    pause_mark_next = in_time_reg;
                end
            end
            sta_pkg::OP_RESUME:
            begin
                if (last_real_time_reg == 32'd0)
                begin
                    last_real_time_next = in_time_reg;
                    relative_time_next  = 32'd0;
                end
                else
                begin
                    last_real_time_next = last_real_time_reg + (in_time_reg - pause_mark_reg);
                    pause_mark_next     = 32'd0;
                end
            end
            sta_pkg::OP_RESET:
            begin
                last_real_time_next = in_time_reg;
                relative_time_next  = 32'd0;
            end
            default:
            begin
                last_real_time_next = last_real_time_reg;
            end
        endcase
    end

    // Hold speed register and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg     <= sta_pkg::TIME_SCALE_RESET;
            last_real_time_reg <= 32'd0;
            relative_time_reg  <= 32'd0;
            pause_mark_reg     <= 32'd0;
        end
        else
        begin
            if (time_scale_we)
            begin
                time_scale_reg <= time_scale_data;
            end
            if (fire)
            begin
                last_real_time_reg <= last_real_time_next;
                relative_time_reg  <= relative_time_next;
                pause_mark_reg     <= pause_mark_next;
            end
        end
    end

    // Advance valid bits of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg   <= sta_pkg::op_t'(req.operation);
            in_time_reg <= req.current_time;
        end
        if (fire)
        begin
            out_warped_reg  <= relative_time_next;
            out_paused_reg  <= paused_flag;
            out_clamped_reg <= clamped_flag;
        end
    end

`ifndef SYNTHESIS
    // A floored step always leaves zero warped time
    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clamped_reg |-> out_warped_reg == 32'd0)
        else $error("clamped result with nonzero warped time");

    // The two flags never come from the same operation
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_paused_reg && out_clamped_reg))
        else $error("both result flags set");

    // Reset operation zeroes warped time and reports zero
    a_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == sta_pkg::OP_RESET
        |=> relative_time_reg == 32'd0 && out_warped_reg == 32'd0)
        else $error("reset operation left nonzero warped time");

    // An ignored pause leaves the pause mark alone
    a_pause_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == sta_pkg::OP_PAUSE && pause_mark_reg != 32'd0
        |=> $stable(pause_mark_reg) && out_paused_reg)
        else $error("repeated pause disturbed pause mark");

    // A stalled request stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_time_reg))
        else $error("stalled request lost");
`endif

endmodule
